// ===== rtl/assert_macros.svh =====
// Assertion helpers, sampled on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/oldm_pkg.sv =====
package oldm_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int POS_W   = 5;
	localparam int STS_W   = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_DEL_AT  = 2'd1,
		OP_DEL_MIN = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0]         status;
		logic signed [DATA_W-1:0] removed_value;
		logic [COUNT_W-1:0]       count;
	} rsp_t;

	typedef enum logic [2:0] {
		DPC_IDLE,
		DPC_LOAD,
		DPC_SCAN,
		DPC_PREP,
		DPC_SHIFT_DN,
		DPC_SHIFT_UP,
		DPC_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    err;
		logic    scan_done;
		logic    up_done;
		logic    dn_done;
	} dp_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_PREP,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_DONE
	} ctl_state_t;

endpackage

// ===== rtl/oldm_datapath.sv =====
`include "assert_macros.svh"

module oldm_datapath import oldm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  req_t     req,
	output dp_stat_t stat,
	output rsp_t     rsp
);

	logic [DATA_W-1:0]        mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]         rd_addr_s1;
	logic                     rd_vld_s1;

	logic [CNT_W-1:0]         cnt_q, ptr_q, end_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic signed [DATA_W-1:0] best_val_q, val_q, removed_q;
	logic                     first_q;
	opcode_t                  op_q;
	status_t                  status_q;
	rsp_t                     rsp_q;

	logic                     re, we;
	logic [IDX_W-1:0]         ra, wa;
	logic [DATA_W-1:0]        wd;
	status_t                  status_d;
	opcode_t                  req_op;

	assign req_op = opcode_t'(req.opcode);

	// request checks, empty ahead of range
	always_comb begin
		status_d = STS_OK;
		unique case (req_op)
			OP_INSERT: begin
				if (32'(cnt_q) >= DEPTH) status_d = STS_FULL;
			end
			OP_DEL_AT: begin
				if (cnt_q == '0) status_d = STS_EMPTY;
				else if (req.position == '0 || 32'(req.position) > 32'(cnt_q))
					status_d = STS_RANGE;
			end
			OP_DEL_MIN: begin
				if (cnt_q == '0) status_d = STS_EMPTY;
			end
			OP_UNUSED: status_d = STS_OK;
		endcase
	end

	assign stat.op        = op_q;
	assign stat.err       = (status_q != STS_OK);
	assign stat.scan_done = (ptr_q >= end_q) && !rd_vld_s1;
	assign stat.up_done   = (ptr_q == '0) && !rd_vld_s1;
	assign stat.dn_done   = (ptr_q >= cnt_q) && !rd_vld_s1;

	// one read and one write port, moves are pipelined through rd_data_s1
	always_comb begin
		re = 1'b0;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = rd_data_s1;
		unique case (cmd.op)
			DPC_SCAN: begin
				if (ptr_q < end_q) begin
					re = 1'b1;
					ra = ptr_q[IDX_W-1:0];
				end
			end
			DPC_SHIFT_UP: begin
				if (ptr_q != '0) begin
					re = 1'b1;
					ra = IDX_W'(ptr_q - 1'b1);
				end
				if (rd_vld_s1) begin
					we = 1'b1;
					wa = IDX_W'(rd_addr_s1 + 1'b1);
				end else if (ptr_q == '0) begin
					we = 1'b1;
					wa = '0;
					wd = val_q;
				end
			end
			DPC_SHIFT_DN: begin
				if (ptr_q < cnt_q) begin
					re = 1'b1;
					ra = ptr_q[IDX_W-1:0];
				end
				if (rd_vld_s1) begin
					we = 1'b1;
					wa = IDX_W'(rd_addr_s1 - 1'b1);
				end
			end
			DPC_IDLE, DPC_LOAD, DPC_PREP, DPC_RESULT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) begin
			rd_data_s1 <= mem[ra];
			rd_addr_s1 <= ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= re;
			if (cmd.op == DPC_SHIFT_UP && stat.up_done) cnt_q <= cnt_q + 1'b1;
			if (cmd.op == DPC_SHIFT_DN && stat.dn_done) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DPC_LOAD: begin
				op_q      <= req_op;
				val_q     <= req.value;
				status_q  <= status_d;
				removed_q <= '0;
				first_q   <= 1'b1;
				unique case (req_op)
					OP_INSERT: ptr_q <= cnt_q;
					OP_DEL_AT: begin
						ptr_q <= CNT_W'(req.position - 1'b1);
						end_q <= CNT_W'(req.position);
					end
					OP_DEL_MIN: begin
						ptr_q <= '0;
						end_q <= cnt_q;
					end
					OP_UNUSED: ;
				endcase
			end
			DPC_SCAN: begin
				if (re) ptr_q <= ptr_q + 1'b1;
				if (rd_vld_s1 && (first_q || rd_data_s1 < best_val_q)) begin
					best_val_q <= rd_data_s1;
					best_idx_q <= rd_addr_s1;
					first_q    <= 1'b0;
				end
			end
			DPC_PREP: begin
				ptr_q     <= CNT_W'(best_idx_q) + 1'b1;
				removed_q <= best_val_q;
			end
			DPC_SHIFT_UP: begin
				if (re) ptr_q <= ptr_q - 1'b1;
			end
			DPC_SHIFT_DN: begin
				if (re) ptr_q <= ptr_q + 1'b1;
			end
			DPC_RESULT: begin
				rsp_q.status        <= status_q;
				rsp_q.removed_value <= removed_q;
				rsp_q.count         <= COUNT_W'(cnt_q);
			end
			DPC_IDLE: ;
			default: ;
		endcase
	end

	assign rsp = rsp_q;

	`ASSERT_CLK(a_cnt_bound, 32'(cnt_q) <= DEPTH, "fill count above depth")
	`ASSERT_NEXT(a_load_keeps_cnt, cmd.op == DPC_LOAD, $stable(cnt_q), "count moved on load")
	`ASSERT_CLK(a_best_held, cmd.op != DPC_PREP || CNT_W'(best_idx_q) < cnt_q,
		"victim past end of list")
	`ASSERT_CLK(a_up_in_range,
		!(cmd.op == DPC_SHIFT_UP && rd_vld_s1) || CNT_W'(rd_addr_s1) < cnt_q,
		"shift up past end of list")

endmodule

// ===== rtl/oldm_ctrl.sv =====
module oldm_ctrl import oldm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic       rsp_vld_q, rsp_vld_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rsp_vld_q <= rsp_vld_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = DPC_IDLE;
		req_ready = 1'b0;
		rsp_vld_d = rsp_vld_q && !rsp_ready;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = DPC_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (stat.err || stat.op == OP_UNUSED) state_d = S_DONE;
				else if (stat.op == OP_INSERT)                state_d = S_SHIFT_UP;
				else                                          state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.op = DPC_SCAN;
				if (stat.scan_done) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.op  = DPC_PREP;
				state_d = S_SHIFT_DN;
			end
			S_SHIFT_DN: begin
				cmd.op = DPC_SHIFT_DN;
				if (stat.dn_done) state_d = S_DONE;
			end
			S_SHIFT_UP: begin
				cmd.op = DPC_SHIFT_UP;
				if (stat.up_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_vld_q || rsp_ready) begin
					cmd.op    = DPC_RESULT;
					rsp_vld_d = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = rsp_vld_q;

endmodule

// ===== rtl/ordered_list_with_delete_min.sv =====
// One request at a time; a refused request or unused opcode skips the walk and goes
// straight to the result. The next request is taken while the previous result still
// waits in its output register.
// Reset (arst_n low, async): list empty, no result pending; entry memory is not cleared.
module ordered_list_with_delete_min import oldm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Controller sequences the walk: dispatch on opcode and checks, then
	//  - insert: shift held entries back one slot, drop value at the front
	//  - delete-at: one-entry scan at pos-1 picks the victim
	//  - delete-min: scan all held entries, first smallest wins
	//  both deletes then close the gap by moving the tail forward.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	oldm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath owns the entry memory, fill count, walk pointer and result register.
	oldm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import oldm_pkg::*;

	localparam int IDLE_LIMIT   = 2000; // cycles with no transaction on either side
	localparam int RANDOM_ITEMS = 700;
	localparam int LONG_HOLD    = 400;  // one long receiver hold-off to back the block up
	localparam int DRAIN_CYCLES = 60;   // quiet time after the last result, catches strays

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	ordered_list_with_delete_min u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Directed rows: the expectation is typed in only where it is obvious,
	// otherwise the list predictor supplies it.
	typedef struct {
		req_t stim;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	plan_row_t plan[$];

	// Predictor state: front of the list sits at index 0.
	logic signed [DATA_W-1:0] list_vals [DEPTH];
	int                       held;

	rsp_t owed[$];   // results still to come, oldest first
	int   errors;
	int   sent;      // accepted request transactions
	int   quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Pull one entry out and close the gap behind it.
	function automatic logic signed [DATA_W-1:0] take_at(input int idx);
		logic signed [DATA_W-1:0] v;
		v = list_vals[idx];
		for (int i = idx; i + 1 < held; i++)
			list_vals[i] = list_vals[i + 1];
		held--;
		return v;
	endfunction

	// Apply one request to the predicted list and return the result it owes.
	function automatic rsp_t list_apply(input req_t r);
		rsp_t o;
		int   best;
		o = '0;
		o.status = STS_OK;
		case (r.opcode)
		OP_INSERT: begin
			if (held >= DEPTH) begin
				o.status = STS_FULL;
			end else begin
				for (int i = held; i > 0; i--)
					list_vals[i] = list_vals[i - 1];
				list_vals[0] = r.value;
				held++;
			end
		end
		OP_DEL_AT: begin
			// empty wins over a bad position
			if (held == 0)
				o.status = STS_EMPTY;
			else if (int'(r.position) < 1 || int'(r.position) > held)
				o.status = STS_RANGE;
			else
				o.removed_value = take_at(int'(r.position) - 1);
		end
		OP_DEL_MIN: begin
			if (held == 0) begin
				o.status = STS_EMPTY;
			end else begin
				// strict compare keeps the first occurrence from the front
				best = 0;
				for (int i = 1; i < held; i++)
					if (list_vals[i] < list_vals[best])
						best = i;
				o.removed_value = take_at(best);
			end
		end
		default: ; // unused opcode: no change, status OK, zero removed value
		endcase
		o.count = COUNT_W'(held);
		return o;
	endfunction

	task automatic add_row(input opcode_t op, input logic signed [DATA_W-1:0] v,
			input logic [POS_W-1:0] p, input bit typed, input status_t st,
			input logic signed [DATA_W-1:0] rv, input logic [COUNT_W-1:0] cnt);
		plan_row_t row;
		row.stim.opcode        = op;
		row.stim.value         = v;
		row.stim.position      = p;
		row.typed              = typed;
		row.want.status        = st;
		row.want.removed_value = rv;
		row.want.count         = cnt;
		plan.push_back(row);
	endtask

	// Random request shaped so the list swings between full and empty:
	// 40-item phases alternate between filling and draining. Small values
	// make duplicate minimums common, full-range values exercise every bit.
	function automatic req_t random_req(input int n);
		req_t r;
		int   roll;
		int   ins_pct;
		if ($urandom_range(0, 1) == 1)
			r.value = $urandom;
		else
			r.value = int'($urandom_range(0, 8)) - 4;
		if (held > 0 && $urandom_range(0, 9) < 8)
			r.position = POS_W'($urandom_range(1, held));
		else
			r.position = POS_W'($urandom_range(0, 16));
		ins_pct = ((n / 40) % 2 == 0) ? 80 : 20;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			r.opcode = OP_UNUSED;
		else if (roll < 4 + ins_pct)
			r.opcode = OP_INSERT;
		else if (roll[0])
			r.opcode = OP_DEL_AT;
		else
			r.opcode = OP_DEL_MIN;
		return r;
	endfunction

	// Sender: idle gap drawn per transaction, every third 64-item stretch runs
	// back to back. Payload and valid change only on the falling edge.
	task automatic offer(input req_t r, input bit typed, input rsp_t want);
		int   gap;
		rsp_t due;
		gap = ((sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		// predictor always advances, even where the row types its own answer
		due = list_apply(r);
		owed.push_back(typed ? want : due);
		sent++;
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b0;
		held      = 0;
		errors    = 0;
		sent      = 0;

		// empty list: both deletes refused, position not even looked at
		add_row(OP_DEL_MIN, 0, 5'd0, 1, STS_EMPTY, 0, 5'd0);
		add_row(OP_DEL_AT, 0, 5'd0, 1, STS_EMPTY, 0, 5'd0);
		// unused opcode does nothing
		add_row(OP_UNUSED, 32'hFFFF_FFFF, 5'd16, 1, STS_OK, 0, 5'd0);
		// value extremes
		add_row(OP_INSERT, 32'h7FFF_FFFF, 5'd0, 1, STS_OK, 0, 5'd1);
		add_row(OP_INSERT, 32'h8000_0000, 5'd0, 1, STS_OK, 0, 5'd2);
		// positions outside 1..count
		add_row(OP_DEL_AT, 0, 5'd0, 1, STS_RANGE, 0, 5'd2);
		add_row(OP_DEL_AT, 0, 5'd16, 1, STS_RANGE, 0, 5'd2);
		// most negative value sits at the front
		add_row(OP_DEL_MIN, 0, 5'd0, 1, STS_OK, 32'h8000_0000, 5'd1);
		// fill to DEPTH; the minimum shows up three times
		for (int i = 0; i < DEPTH - 1; i++)
			add_row(OP_INSERT, (i % 5 == 2) ? -20 : i - 5, 5'd0, 0, STS_OK, 0, 5'd0);
		add_row(OP_INSERT, 32'h1234_5678, 5'd0, 1, STS_FULL, 0, 5'd16);
		// last slot, then first occurrence of a duplicated minimum
		add_row(OP_DEL_AT, 0, 5'd16, 0, STS_OK, 0, 5'd0);
		add_row(OP_DEL_MIN, 0, 5'd0, 0, STS_OK, 0, 5'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			offer(plan[i].stim, plan[i].typed, plan[i].want);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			offer(random_req(n), 1'b0, '0);

		@(negedge clk);
		req_valid <= 1'b0;

		while (owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS ordered_list_with_delete_min");
		else
			$display("FAIL ordered_list_with_delete_min");
		$finish;
	end

	// Receiver: random hold-off per transaction, no-stall stretches, and one
	// long hold-off so the block fills its output and stops taking requests.
	initial begin : result_side
		int   gap;
		int   seen;
		bit   long_done;
		rsp_t want;
		seen      = 0;
		long_done = 0;
		@(posedge arst_n);
		forever begin
			gap = ((seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (!long_done && seen == 120) begin
				long_done = 1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			seen++;
			if (owed.size() == 0) begin
				errors++;
				$error("result transaction with nothing outstanding (status %0d)", rsp.status);
			end else begin
				want = owed.pop_front();
				if (rsp.status !== want.status) begin
					errors++;
					$error("status: expected %0d, got %0d", want.status, rsp.status);
				end
				if (rsp.removed_value !== want.removed_value) begin
					errors++;
					$error("removed_value: expected %0d, got %0d",
						want.removed_value, rsp.removed_value);
				end
				if (rsp.count !== want.count) begin
					errors++;
					$error("count: expected %0d, got %0d", want.count, rsp.count);
				end
			end
		end
	end

	// Watchdog: any transaction on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAIL ordered_list_with_delete_min");
				$finish;
			end
		end
	end

endmodule
